@@ rtl/btpc_pkg.sv @@
// Shared types, constants and calibration register codes for the pressure compensation block.
`timescale 1ns / 1ps
package btpc_pkg;

    // Fixed-point scaling of the two outputs.
    localparam int TEMP_FRAC_BITS  = 16;
    localparam int PRESS_FRAC_BITS = 6;
    localparam int TEMP_DEN_BITS   = 48;
    localparam int PRESS_DEN_BITS  = 181;
    localparam int TEMP_SHIFT      = TEMP_DEN_BITS - TEMP_FRAC_BITS;
    localparam int PRESS_SHIFT     = PRESS_DEN_BITS - PRESS_FRAC_BITS;

    // Internal widths: accumulator, temperature numerator, coefficients, multiplier operand.
    localparam int ACC_W  = 224;
    localparam int N_W    = 60;
    localparam int COEF_W = 17;
    localparam int MUL_W  = 33;

    // Alignment of each coefficient in the pressure Horner chains.
    localparam int SH_P3  = 53;
    localparam int SH_P2  = 104;
    localparam int SH_P1  = 161;
    localparam int SH_P7  = 55;
    localparam int SH_P6  = 105;
    localparam int SH_P5  = 162;
    localparam int SH_P9  = 48;
    localparam int SH_P11 = 31;
    localparam int SH_H1  = 85;
    localparam int SH_A   = 22;

    // Cycles from the input register to the output register.
    localparam int PIPE_LAT = 17;

    localparam logic signed [COEF_W-1:0] PRESS_OFFSET = 17'sd16384;

    localparam logic signed [23:0] TQ_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] TQ_MIN = 24'sh800000;
    localparam logic [22:0]        PQ_MAX = 23'h7FFFFF;

    localparam logic signed [ACC_W-1:0] PQ_MAX_W = ACC_W'(8388607);

    typedef enum logic [1:0] {
        CFG_TEMP_CALIB = 2'd0,
        CFG_PRESS_A    = 2'd1,
        CFG_PRESS_B    = 2'd2,
        CFG_PRESS_C    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0] raw_temperature;
        logic [23:0] raw_pressure;
    } t_in;

    typedef struct packed {
        logic signed [23:0] temperature_q;
        logic [22:0]        pressure_q;
    } t_out;

endpackage

@@ rtl/btpc_delay.sv @@
// Fixed-length register delay line for words that travel beside the arithmetic.
`timescale 1ns / 1ps
module btpc_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_d
);

    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        r_line[0] <= i_d;
        for (int k = 1; k < DEPTH; k++) begin
            r_line[k] <= r_line[k-1];
        end
    end

    assign o_d = r_line[DEPTH-1];

endmodule

@@ rtl/btpc_mac.sv @@
// Two-stage wide multiply-add: y = x * m + z, modulo 2^W, with m a signed 33-bit operand.
`timescale 1ns / 1ps
module btpc_mac #(
    parameter int W = btpc_pkg::ACC_W
) (
    input  logic                              i_clk,
    input  logic [W-1:0]                      i_x,
    input  logic signed [btpc_pkg::MUL_W-1:0] i_m,
    input  logic [W-1:0]                      i_z,
    output logic [W-1:0]                      o_y
);

    localparam int NCH = (W + 31) / 32;
    localparam int PW  = 2 * btpc_pkg::MUL_W;

    logic [NCH*32-1:0]   x_ext;
    logic signed [PW-1:0] r_prod [NCH];
    logic [W-1:0]        r_z;
    logic [W-1:0]        r_y;
    logic [W-1:0]        n_y;
    logic [W-1:0]        term;

    assign x_ext = (NCH*32)'(i_x);

    // Each 32-bit slice of x is taken as unsigned; the sum is exact modulo 2^W.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NCH; k++) begin
            r_prod[k] <= $signed({1'b0, x_ext[32*k +: 32]}) * i_m;
        end
        r_z <= i_z;
        r_y <= n_y;
    end

    always_comb begin
        term = '0;
        n_y  = r_z;
        for (int k = 0; k < NCH; k++) begin
            term = W'(r_prod[k]) << (32 * k);
            n_y  = n_y + term;
        end
    end

    assign o_y = r_y;

endmodule

@@ rtl/btpc_nmul.sv @@
// Horner step by the 60-bit temperature numerator: y = x * n + (k << SHIFT), in two passes.
`timescale 1ns / 1ps
module btpc_nmul #(
    parameter int W     = btpc_pkg::ACC_W,
    parameter int SHIFT = 64
) (
    input  logic                               i_clk,
    input  logic [W-1:0]                       i_x,
    input  logic signed [btpc_pkg::N_W-1:0]    i_n,
    input  logic signed [btpc_pkg::COEF_W-1:0] i_k,
    output logic [W-1:0]                       o_y
);

    logic signed [btpc_pkg::MUL_W-1:0] m_hi;
    logic signed [btpc_pkg::MUL_W-1:0] m_lo;
    logic [W-1:0]  z_hi;
    logic [W-1:0]  y_hi;
    logic [W-1:0]  x_d;
    logic [31:0]   nlo_d;

    // The coefficient term has at least 32 zero low bits, so it can enter the high pass
    // pre-shifted and the high partial result is moved up by 32 before the low pass.
    assign m_hi = btpc_pkg::MUL_W'($signed(i_n[btpc_pkg::N_W-1:32]));
    assign z_hi = W'(i_k) << (SHIFT - 32);

    btpc_mac #(.W(W)) u_mac_hi (
        .i_clk (i_clk),
        .i_x   (i_x),
        .i_m   (m_hi),
        .i_z   (z_hi),
        .o_y   (y_hi)
    );

    btpc_delay #(.WIDTH(W + 32), .DEPTH(2)) u_dly (
        .i_clk (i_clk),
        .i_d   ({i_x, i_n[31:0]}),
        .o_d   ({x_d, nlo_d})
    );

    assign m_lo = $signed({1'b0, nlo_d});

    btpc_mac #(.W(W)) u_mac_lo (
        .i_clk (i_clk),
        .i_x   (x_d),
        .i_m   (m_lo),
        .i_z   (y_hi << 32),
        .o_y   (o_y)
    );

endmodule

@@ rtl/btpc_temp.sv @@
// Temperature front end: numerator of the quadratic, then the rounded and saturated Q8.16 value.
`timescale 1ns / 1ps
module btpc_temp #(
    parameter int FRAC_BITS = btpc_pkg::TEMP_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic [23:0]                     i_raw_t,
    input  logic [15:0]                     i_t1,
    input  logic [15:0]                     i_t2,
    input  logic signed [7:0]               i_t3,
    output logic signed [btpc_pkg::N_W-1:0] o_n,
    output logic signed [23:0]              o_tq
);

    localparam int SHIFT = btpc_pkg::TEMP_DEN_BITS - FRAC_BITS;

    localparam logic signed [60:0] TMAX_W = 61'sd8388607;
    localparam logic signed [60:0] TMIN_W = -61'sd8388608;
    localparam logic signed [60:0] T_HALF = 61'sd1 <<< (SHIFT - 1);

    logic signed [25:0] d;
    logic signed [51:0] sq;
    logic signed [42:0] n_p1;
    logic signed [42:0] r_p1;
    logic [48:0]        r_p2;
    logic signed [57:0] t3prod;
    logic signed [59:0] p1x;
    logic signed [59:0] n_n;
    logic signed [59:0] r_n;
    logic signed [60:0] rnd;
    logic signed [60:0] shf;
    logic signed [23:0] n_tq;
    logic signed [23:0] r_tq;

    assign d    = $signed({2'b0, i_raw_t}) - $signed({2'b0, i_t1, 8'b0});
    assign sq   = d * d;
    assign n_p1 = d * $signed({1'b0, i_t2});

    assign t3prod = $signed({1'b0, r_p2}) * i_t3;
    assign p1x    = 60'(r_p1);
    assign n_n    = (p1x <<< 18) + 60'(t3prod);

    assign rnd = 61'(r_n) + T_HALF;
    assign shf = rnd >>> SHIFT;

    always_comb begin
        if (shf > TMAX_W) begin
            n_tq = btpc_pkg::TQ_MAX;
        end else if (shf < TMIN_W) begin
            n_tq = btpc_pkg::TQ_MIN;
        end else begin
            n_tq = shf[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1 <= n_p1;
        r_p2 <= sq[48:0];
        r_n  <= n_n;
        r_tq <= n_tq;
    end

    assign o_n  = r_n;
    assign o_tq = r_tq;

endmodule

@@ rtl/baro_temp_pressure_compensation.sv @@
// Top level of the barometric temperature and pressure compensation pipeline.
// A word is taken at every clock edge where start is high; busy stays low, so a new
// sample pair may follow every cycle. Each result appears on o_result with o_strobe high for
// one cycle, after two temperature stages, seven multiply-add passes of the pressure Horner
// chain and the output register. The receiver cannot hold results off. Calibration
// registers are written through the configuration channel, which is always ready, and
// must only change while no sample is in flight.
`timescale 1ns / 1ps
module baro_temp_pressure_compensation #(
    parameter int TEMP_FRAC_BITS  = btpc_pkg::TEMP_FRAC_BITS,
    parameter int PRESS_FRAC_BITS = btpc_pkg::PRESS_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  btpc_pkg::t_in    i_item,
    output logic             o_strobe,
    output btpc_pkg::t_out   o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [47:0]      i_cfg_data
);

    localparam int W           = btpc_pkg::ACC_W;
    localparam int LAT         = btpc_pkg::PIPE_LAT;
    localparam int PRESS_SHIFT = btpc_pkg::PRESS_DEN_BITS - PRESS_FRAC_BITS;

    localparam logic signed [W-1:0] P_HALF = W'(1) << (PRESS_SHIFT - 1);

    logic [39:0] r_temp_calib;
    logic [47:0] r_press_a;
    logic [47:0] r_press_b;
    logic [31:0] r_press_c;

    btpc_pkg::t_in  r_s0;
    logic           r_s0_vld;
    logic [LAT-1:0] r_vld;
    btpc_pkg::t_out r_out;
    btpc_pkg::t_out n_out;

    // Calibration fields.
    logic [15:0] t1, t2;
    logic signed [7:0] t3;
    logic signed [btpc_pkg::COEF_W-1:0] p1, p2, p5, p6;
    logic signed [7:0] p3, p4, p7, p8, p10, p11;
    logic signed [15:0] p9;

    logic signed [btpc_pkg::N_W-1:0] n0, n_d2, n_d6, n_d8;
    logic signed [23:0] tq0, tq_d;
    logic [23:0] r_d10, r_d12, r_d14;
    logic [W-1:0] a1, a2, a3, a_d;
    logic [W-1:0] b1, b2, b3;
    logic [W-1:0] h1, h2, h3;
    logic signed [32:0] rp11;
    logic [W-1:0] z_h1;
    logic signed [W-1:0] h3_s, rndp, qp;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib <= '0;
            r_press_a    <= '0;
            r_press_b    <= '0;
            r_press_c    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (btpc_pkg::t_cfg_idx'(i_cfg_index))
                btpc_pkg::CFG_TEMP_CALIB: r_temp_calib <= i_cfg_data[39:0];
                btpc_pkg::CFG_PRESS_A:    r_press_a    <= i_cfg_data;
                btpc_pkg::CFG_PRESS_B:    r_press_b    <= i_cfg_data;
                btpc_pkg::CFG_PRESS_C:    r_press_c    <= i_cfg_data[31:0];
                default:                  r_press_c    <= r_press_c;
            endcase
        end
    end

    assign t1  = r_temp_calib[15:0];
    assign t2  = r_temp_calib[31:16];
    assign t3  = $signed(r_temp_calib[39:32]);
    assign p1  = $signed({r_press_a[15], r_press_a[15:0]}) - btpc_pkg::PRESS_OFFSET;
    assign p2  = $signed({r_press_a[31], r_press_a[31:16]}) - btpc_pkg::PRESS_OFFSET;
    assign p3  = $signed(r_press_a[39:32]);
    assign p4  = $signed(r_press_a[47:40]);
    assign p5  = $signed({1'b0, r_press_b[15:0]});
    assign p6  = $signed({1'b0, r_press_b[31:16]});
    assign p7  = $signed(r_press_b[39:32]);
    assign p8  = $signed(r_press_b[47:40]);
    assign p9  = $signed(r_press_c[15:0]);
    assign p10 = $signed(r_press_c[23:16]);
    assign p11 = $signed(r_press_c[31:24]);

    // Input register and valid pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_vld    <= '0;
        end else begin
            r_s0_vld <= start && !busy;
            r_vld    <= {r_vld[LAT-2:0], r_s0_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0  <= i_item;
        r_out <= n_out;
    end

    btpc_temp #(.FRAC_BITS(TEMP_FRAC_BITS)) u_temp (
        .i_clk   (i_clk),
        .i_raw_t (r_s0.raw_temperature),
        .i_t1    (t1),
        .i_t2    (t2),
        .i_t3    (t3),
        .o_n     (n0),
        .o_tq    (tq0)
    );

    btpc_delay #(.WIDTH(24), .DEPTH(13)) u_dly_tq (
        .i_clk (i_clk), .i_d (tq0), .o_d (tq_d)
    );

    btpc_delay #(.WIDTH(btpc_pkg::N_W), .DEPTH(2)) u_dly_n2 (
        .i_clk (i_clk), .i_d (n0), .o_d (n_d2)
    );
    btpc_delay #(.WIDTH(btpc_pkg::N_W), .DEPTH(4)) u_dly_n6 (
        .i_clk (i_clk), .i_d (n_d2), .o_d (n_d6)
    );
    btpc_delay #(.WIDTH(btpc_pkg::N_W), .DEPTH(2)) u_dly_n8 (
        .i_clk (i_clk), .i_d (n_d6), .o_d (n_d8)
    );

    btpc_delay #(.WIDTH(24), .DEPTH(10)) u_dly_r10 (
        .i_clk (i_clk), .i_d (r_s0.raw_pressure), .o_d (r_d10)
    );
    btpc_delay #(.WIDTH(24), .DEPTH(2)) u_dly_r12 (
        .i_clk (i_clk), .i_d (r_d10), .o_d (r_d12)
    );
    btpc_delay #(.WIDTH(24), .DEPTH(2)) u_dly_r14 (
        .i_clk (i_clk), .i_d (r_d12), .o_d (r_d14)
    );

    // Raw-pressure-independent cubic in T: ((P8 n + P7') n + P6') n + P5'.
    btpc_mac #(.W(W)) u_mac_a1 (
        .i_clk (i_clk),
        .i_x   (W'(n0)),
        .i_m   (btpc_pkg::MUL_W'(p8)),
        .i_z   (W'(p7) << btpc_pkg::SH_P7),
        .o_y   (a1)
    );
    btpc_nmul #(.W(W), .SHIFT(btpc_pkg::SH_P6)) u_nmul_a2 (
        .i_clk (i_clk), .i_x (a1), .i_n (n_d2), .i_k (p6), .o_y (a2)
    );
    btpc_nmul #(.W(W), .SHIFT(btpc_pkg::SH_P5)) u_nmul_a3 (
        .i_clk (i_clk), .i_x (a2), .i_n (n_d6), .i_k (p5), .o_y (a3)
    );
    btpc_delay #(.WIDTH(W), .DEPTH(2)) u_dly_a (
        .i_clk (i_clk), .i_d (a3), .o_d (a_d)
    );

    // Cubic in T that multiplies the raw pressure once.
    btpc_mac #(.W(W)) u_mac_b1 (
        .i_clk (i_clk),
        .i_x   (W'(n0)),
        .i_m   (btpc_pkg::MUL_W'(p4)),
        .i_z   (W'(p3) << btpc_pkg::SH_P3),
        .o_y   (b1)
    );
    btpc_nmul #(.W(W), .SHIFT(btpc_pkg::SH_P2)) u_nmul_b2 (
        .i_clk (i_clk), .i_x (b1), .i_n (n_d2), .i_k (p2), .o_y (b2)
    );
    btpc_nmul #(.W(W), .SHIFT(btpc_pkg::SH_P1)) u_nmul_b3 (
        .i_clk (i_clk), .i_x (b2), .i_n (n_d6), .i_k (p1), .o_y (b3)
    );

    // Horner in the raw pressure: h1 = P10 n + P9' + r P11', h2 = B + r h1', h3 = A + r h2.
    assign rp11 = $signed({1'b0, r_d10}) * p11;
    assign z_h1 = (W'(rp11) << btpc_pkg::SH_P11) + (W'(p9) << btpc_pkg::SH_P9);

    btpc_mac #(.W(W)) u_mac_h1 (
        .i_clk (i_clk),
        .i_x   (W'(n_d8)),
        .i_m   (btpc_pkg::MUL_W'(p10)),
        .i_z   (z_h1),
        .o_y   (h1)
    );
    btpc_mac #(.W(W)) u_mac_h2 (
        .i_clk (i_clk),
        .i_x   (h1 << btpc_pkg::SH_H1),
        .i_m   ($signed({9'b0, r_d12})),
        .i_z   (b3),
        .o_y   (h2)
    );
    btpc_mac #(.W(W)) u_mac_h3 (
        .i_clk (i_clk),
        .i_x   (h2),
        .i_m   ($signed({9'b0, r_d14})),
        .i_z   (a_d << btpc_pkg::SH_A),
        .o_y   (h3)
    );

    // Round to nearest with ties up, then clamp to the unsigned output range.
    assign h3_s = $signed(h3);
    assign rndp = h3_s + P_HALF;
    assign qp   = rndp >>> PRESS_SHIFT;

    always_comb begin
        n_out.temperature_q = tq_d;
        if (qp < 0) begin
            n_out.pressure_q = '0;
        end else if (qp > btpc_pkg::PQ_MAX_W) begin
            n_out.pressure_q = btpc_pkg::PQ_MAX;
        end else begin
            n_out.pressure_q = qp[22:0];
        end
    end

    assign o_strobe = r_vld[LAT-1];
    assign o_result = r_out;

`ifndef SYNTH
    a_strobe_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_s0_vld, LAT))
        else $error("result strobe without a word taken at the matching cycle");

    a_word_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_s0_vld)
        else $error("accepted word did not enter the pipeline");

    a_temp_calib_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == btpc_pkg::CFG_TEMP_CALIB)
        |=> (r_temp_calib == $past(i_cfg_data[39:0])))
        else $error("temperature calibration write was lost");
`endif

endmodule
